### rtl/esc_pkg.sv
// Shared types, codes and constants for the environmental sensor compensation block.
package esc_pkg;

    // operation codes
    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HUMID = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP       = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_NINE = 3'd3;
    localparam logic [2:0] REG_HUMID      = 3'd4;
    localparam logic [2:0] REG_OFFSET     = 3'd5;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // arithmetic right shift on a 32-bit two's complement word
    function automatic word_t asr(input word_t v, input int unsigned s);
        return word_t'($signed(v) >>> s);
    endfunction

    // sign-extend a 16-bit field
    function automatic word_t sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### rtl/esc_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module esc_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  esc_pkg::word_t dividend,
    input  esc_pkg::word_t divisor,
    output logic           busy,
    output esc_pkg::word_t quotient
);
    import esc_pkg::*;

    logic [WORD_W:0]   rem_reg, rem_next;
    word_t             quo_reg, quo_next;
    word_t             dvs_reg, dvs_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_sub;

    // one shift-compare-subtract step
    always_comb
    begin
        rem_shift = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[WORD_W])
            begin
                rem_next = rem_sub;
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(WORD_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < 6'(WORD_W)) else $error("divider count overrun");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> cnt_reg == 6'(WORD_W)) else $error("divider ended early");

endmodule

### rtl/env_sensor_compensation.sv
// Top level: sequencer around a shared 32x32 multiplier and a shared divider.
// The pressure path includes a divide on the shared divider; temperature, humidity and unused codes do not.
// Throughput: one item at a time; the input is stalled until the result is registered.
// The result register lets the next item start while the last result waits.
// Reset (rst_n, async low) clears coefficients, fine temperature and all control state.
module env_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [19:0] raw_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [32:0] reading,
    output logic        zero_divisor,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import esc_pkg::*;

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_NULL = 6'd1;
    localparam logic [5:0] S_T0   = 6'd2;
    localparam logic [5:0] S_T1   = 6'd3;
    localparam logic [5:0] S_T2   = 6'd4;
    localparam logic [5:0] S_T3   = 6'd5;
    localparam logic [5:0] S_T4   = 6'd6;
    localparam logic [5:0] S_T5   = 6'd7;
    localparam logic [5:0] S_T6   = 6'd8;
    localparam logic [5:0] S_T7   = 6'd9;
    localparam logic [5:0] S_P0   = 6'd10;
    localparam logic [5:0] S_P1   = 6'd11;
    localparam logic [5:0] S_P2   = 6'd12;
    localparam logic [5:0] S_P3   = 6'd13;
    localparam logic [5:0] S_P4   = 6'd14;
    localparam logic [5:0] S_P5   = 6'd15;
    localparam logic [5:0] S_P6   = 6'd16;
    localparam logic [5:0] S_P7   = 6'd17;
    localparam logic [5:0] S_P8   = 6'd18;
    localparam logic [5:0] S_P9   = 6'd19;
    localparam logic [5:0] S_P10  = 6'd20;
    localparam logic [5:0] S_P11  = 6'd21;
    localparam logic [5:0] S_P12  = 6'd22;
    localparam logic [5:0] S_P13  = 6'd23;
    localparam logic [5:0] S_P14  = 6'd24;
    localparam logic [5:0] S_PZ   = 6'd25;
    localparam logic [5:0] S_H0   = 6'd26;
    localparam logic [5:0] S_H1   = 6'd27;
    localparam logic [5:0] S_H2   = 6'd28;
    localparam logic [5:0] S_H3   = 6'd29;
    localparam logic [5:0] S_H4   = 6'd30;
    localparam logic [5:0] S_H5   = 6'd31;
    localparam logic [5:0] S_H6   = 6'd32;
    localparam logic [5:0] S_H7   = 6'd33;
    localparam logic [5:0] S_H8   = 6'd34;
    localparam logic [5:0] S_H9   = 6'd35;

    localparam word_t C_64000  = 32'd64000;
    localparam word_t C_2P20   = 32'd1048576;
    localparam word_t C_3125   = 32'd3125;
    localparam word_t C_76800  = 32'd76800;
    localparam word_t C_16384  = 32'd16384;
    localparam word_t C_32768  = 32'd32768;
    localparam word_t C_2P21   = 32'd2097152;
    localparam word_t C_8192   = 32'd8192;
    localparam word_t C_HMAX   = 32'd419430400;
    localparam word_t C_SIGN   = 32'h80000000;
    localparam word_t C_INV5   = 32'd52429;
    localparam word_t C_51     = 32'd51;

    // configuration registers
    logic [47:0] temp_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] pnine_reg;
    logic [63:0] humid_reg;
    logic [15:0] offset_reg;

    logic [5:0]  state_reg, state_next;
    logic [19:0] raw_reg, raw_next;
    word_t       fine_reg, fine_next;
    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    word_t       c_reg, c_next;
    word_t       d_reg, d_next;
    word_t       prod_reg;
    logic        half_reg, half_next;
    logic        neg_reg, neg_next;
    logic        out_valid_reg, out_valid_next;
    logic [32:0] reading_reg, reading_next;
    logic        zdiv_reg, zdiv_next;

    word_t       mul_a, mul_b;
    word_t       prod_full;
    logic        div_start;
    word_t       div_dividend, div_divisor, div_quo;
    logic        div_busy;
    logic        can_emit;
    logic        in_xfer;

    // coefficient fields
    word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    word_t h1, h2, h3, h4, h5, h6;
    word_t off_abs, tmp0, tmp1, sat;

    assign t1 = {16'd0, temp_reg[15:0]};
    assign t2 = sx16(temp_reg[31:16]);
    assign t3 = sx16(temp_reg[47:32]);
    assign p1 = {16'd0, plow_reg[15:0]};
    assign p2 = sx16(plow_reg[31:16]);
    assign p3 = sx16(plow_reg[47:32]);
    assign p4 = sx16(plow_reg[63:48]);
    assign p5 = sx16(phigh_reg[15:0]);
    assign p6 = sx16(phigh_reg[31:16]);
    assign p7 = sx16(phigh_reg[47:32]);
    assign p8 = sx16(phigh_reg[63:48]);
    assign p9 = sx16(pnine_reg);
    assign h1 = {24'd0, humid_reg[7:0]};
    assign h2 = sx16(humid_reg[23:8]);
    assign h3 = {24'd0, humid_reg[31:24]};
    assign h4 = {{20{humid_reg[43]}}, humid_reg[43:32]};
    assign h5 = {{20{humid_reg[55]}}, humid_reg[55:44]};
    assign h6 = {{24{humid_reg[63]}}, humid_reg[63:56]};

    // magnitude of the user offset
    assign off_abs  = offset_reg[15] ? (word_t'(0) - sx16(offset_reg)) : sx16(offset_reg);
    assign in_xfer  = in_valid && !in_stall;
    assign can_emit = !(out_valid_reg && out_stall);

    // shared multiplier, low word kept
    assign prod_full = mul_a * mul_b;

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        fine_next      = fine_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        half_next      = half_reg;
        neg_next       = neg_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        tmp0           = '0;
        tmp1           = '0;
        sat            = '0;
        out_valid_next = out_valid_reg && out_stall;
        reading_next   = reading_reg;
        zdiv_next      = zdiv_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    raw_next = raw_value;
                    unique case (operation)
                        OP_TEMP:  state_next = S_T0;
                        OP_PRESS: state_next = S_P0;
                        OP_HUMID: state_next = S_H0;
                        default:  state_next = S_NULL;
                    endcase
                end
            end
            S_NULL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    reading_next   = '0;
                    zdiv_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            // temperature
            S_T0:
            begin
                a_next     = {12'd0, raw_reg} >> 3;
                a_next     = a_next - (t1 << 1);
                b_next     = ({12'd0, raw_reg} >> 4) - t1;
                neg_next   = offset_reg[15];
                // |ofs|/5 by reciprocal, exact for a 16-bit magnitude
                mul_a      = off_abs;
                mul_b      = C_INV5;
                state_next = S_T1;
            end
            S_T1:
            begin
                // |ofs|*256/5 = 51*|ofs| + |ofs|/5
                d_next     = (off_abs * C_51) + (prod_reg >> 18);
                mul_a      = a_reg;
                mul_b      = t2;
                state_next = S_T2;
            end
            S_T2:
            begin
                a_next     = asr(prod_reg, 11);
                mul_a      = b_reg;
                mul_b      = b_reg;
                state_next = S_T3;
            end
            S_T3:
            begin
                mul_a      = asr(prod_reg, 12);
                mul_b      = t3;
                state_next = S_T4;
            end
            S_T4:
            begin
                a_next     = a_reg + asr(prod_reg, 14);
                state_next = S_T5;
            end
            S_T5:
            begin
                fine_next  = a_reg + (neg_reg ? (word_t'(0) - d_reg) : d_reg);
                state_next = S_T6;
            end
            S_T6:
            begin
                mul_a      = fine_reg;
                mul_b      = 32'd5;
                state_next = S_T7;
            end
            S_T7:
            begin
                tmp0 = asr(prod_reg + 32'd128, 8);
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    reading_next   = {tmp0[WORD_W-1], tmp0};
                    zdiv_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            // pressure
            S_P0:
            begin
                a_next     = asr(fine_reg, 1) - C_64000;
                state_next = S_P1;
            end
            S_P1:
            begin
                mul_a      = asr(a_reg, 2);
                mul_b      = asr(a_reg, 2);
                state_next = S_P2;
            end
            S_P2:
            begin
                b_next     = prod_reg;
                mul_a      = asr(prod_reg, 11);
                mul_b      = p6;
                state_next = S_P3;
            end
            S_P3:
            begin
                c_next     = prod_reg;
                mul_a      = a_reg;
                mul_b      = p5;
                state_next = S_P4;
            end
            S_P4:
            begin
                c_next     = asr(c_reg + (prod_reg << 1), 2) + (p4 << 16);
                mul_a      = p3;
                mul_b      = asr(b_reg, 13);
                state_next = S_P5;
            end
            S_P5:
            begin
                d_next     = prod_reg;
                mul_a      = p2;
                mul_b      = a_reg;
                state_next = S_P6;
            end
            S_P6:
            begin
                a_next     = asr(asr(d_reg, 3) + asr(prod_reg, 1), 18);
                state_next = S_P7;
            end
            S_P7:
            begin
                mul_a      = C_32768 + a_reg;
                mul_b      = p1;
                state_next = S_P8;
            end
            S_P8:
            begin
                a_next = asr(prod_reg, 15);
                tmp0   = (C_2P20 - {12'd0, raw_reg}) - asr(c_reg, 12);
                mul_a  = tmp0;
                mul_b  = C_3125;
                if (asr(prod_reg, 15) == '0)
                    state_next = S_PZ;
                else
                    state_next = S_P9;
            end
            S_PZ:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    reading_next   = '0;
                    zdiv_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_P9:
            begin
                half_next    = (prod_reg >= C_SIGN);
                div_start    = 1'b1;
                div_dividend = (prod_reg < C_SIGN) ? (prod_reg << 1) : prod_reg;
                div_divisor  = a_reg;
                state_next   = S_P10;
            end
            S_P10:
            begin
                if (!div_busy)
                begin
                    b_next     = half_reg ? (div_quo << 1) : div_quo;
                    state_next = S_P11;
                end
            end
            S_P11:
            begin
                mul_a      = b_reg >> 3;
                mul_b      = b_reg >> 3;
                state_next = S_P12;
            end
            S_P12:
            begin
                mul_a      = p9;
                mul_b      = prod_reg >> 13;
                state_next = S_P13;
            end
            S_P13:
            begin
                d_next     = asr(prod_reg, 12);
                mul_a      = b_reg >> 2;
                mul_b      = p8;
                state_next = S_P14;
            end
            S_P14:
            begin
                tmp0 = b_reg + asr(d_reg + asr(prod_reg, 13) + p7, 4);
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    reading_next   = {1'b0, tmp0};
                    zdiv_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            // humidity
            S_H0:
            begin
                a_next     = fine_reg - C_76800;
                state_next = S_H1;
            end
            S_H1:
            begin
                mul_a      = h5;
                mul_b      = a_reg;
                state_next = S_H2;
            end
            S_H2:
            begin
                b_next     = ({16'd0, raw_reg[15:0]} << 14) - (h4 << 20) - prod_reg;
                mul_a      = a_reg;
                mul_b      = h6;
                state_next = S_H3;
            end
            S_H3:
            begin
                b_next     = asr(b_reg + C_16384, 15);
                c_next     = asr(prod_reg, 10);
                mul_a      = a_reg;
                mul_b      = h3;
                state_next = S_H4;
            end
            S_H4:
            begin
                mul_a      = c_reg;
                mul_b      = asr(prod_reg, 11) + C_32768;
                state_next = S_H5;
            end
            S_H5:
            begin
                mul_a      = asr(prod_reg, 10) + C_2P21;
                mul_b      = h2;
                state_next = S_H6;
            end
            S_H6:
            begin
                mul_a      = b_reg;
                mul_b      = asr(prod_reg + C_8192, 14);
                state_next = S_H7;
            end
            S_H7:
            begin
                c_next     = prod_reg;
                mul_a      = asr(prod_reg, 15);
                mul_b      = asr(prod_reg, 15);
                state_next = S_H8;
            end
            S_H8:
            begin
                mul_a      = asr(prod_reg, 7);
                mul_b      = h1;
                state_next = S_H9;
            end
            S_H9:
            begin
                tmp0 = c_reg - asr(prod_reg, 4);
                // clamp to the valid humidity range
                if (tmp0[WORD_W-1])
                    sat = '0;
                else if (tmp0 > C_HMAX)
                    sat = C_HMAX;
                else
                    sat = tmp0;
                tmp1 = ((sat >> 12) * 32'd25) >> 8;
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    reading_next   = {1'b0, tmp1};
                    zdiv_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fine_reg      <= '0;
            out_valid_reg <= 1'b0;
            temp_reg      <= '0;
            plow_reg      <= '0;
            phigh_reg     <= '0;
            pnine_reg     <= '0;
            humid_reg     <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fine_reg      <= fine_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TEMP:       temp_reg   <= cfg_data[47:0];
                    REG_PRESS_LOW:  plow_reg   <= cfg_data;
                    REG_PRESS_HIGH: phigh_reg  <= cfg_data;
                    REG_PRESS_NINE: pnine_reg  <= cfg_data[15:0];
                    REG_HUMID:      humid_reg  <= cfg_data;
                    REG_OFFSET:     offset_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        half_reg    <= half_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_full;
        reading_reg <= reading_next;
        zdiv_reg    <= zdiv_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign reading      = reading_reg;
    assign zero_divisor = zdiv_reg;

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy) else $error("divider busy while idle");
    a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divisor) |-> (reading == '0)) else $error("flagged reading not zero");
    a_press_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && operation == OP_PRESS) |=> (state_reg == S_P0))
        else $error("pressure item did not start");
    a_fine_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_T5) |=> $stable(fine_reg)) else $error("fine temperature changed");

endmodule

### bench/tb_env_sensor_compensation.sv
// Testbench for the environmental sensor compensation block: random and directed readings
module tb_env_sensor_compensation;
    import esc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [19:0] raw;
    } sample_t;

    typedef struct packed
    {
        logic [32:0] value;
        logic        zdiv;
    } comp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [19:0] raw_value;
    logic        out_valid;
    logic        out_stall;
    logic [32:0] reading;
    logic        zero_divisor;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    env_sensor_compensation u_top (.*);

    // predictor copy of registers and state
    logic [47:0] cal_temp;
    logic [63:0] cal_plo;
    logic [63:0] cal_phi;
    logic [15:0] cal_p9;
    logic [63:0] cal_hum;
    logic [15:0] cal_ofs;
    logic [31:0] fine_t;

    sample_t pending_samples[$];
    comp_t   expected_readings[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      fail_count;
    int      cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] sra(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = (32'd1 << bits) - 1;
        v = v & m;
        if (v[bits-1])
            v = v | ~m;
        return v;
    endfunction

    // temperature: updates fine temperature, returns degC*100
    function automatic comp_t calc_temp(input logic [31:0] adc);
        logic [31:0] t1, t2, t3, a, b, t;
        int signed   adj;
        comp_t       r;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sext({16'd0, cal_temp[31:16]}, 16);
        t3 = sext({16'd0, cal_temp[47:32]}, 16);
        a = (adc >> 3) - (t1 << 1);
        b = (adc >> 4) - t1;
        a = sra(a * t2, 11);
        b = sra(sra(b * b, 12) * t3, 14);
        adj = $signed(cal_ofs) * 256;
        fine_t = a + b + 32'(adj / 5);
        t = sra(fine_t * 32'd5 + 32'd128, 8);
        r.value = {t[31], t};
        r.zdiv = 1'b0;
        return r;
    endfunction

    // pressure in Pa, zero with flag on a zero divisor
    function automatic comp_t calc_press(input logic [31:0] adc);
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q, sq, p, ps;
        comp_t       r;
        p1 = {16'd0, cal_plo[15:0]};
        p2 = sext({16'd0, cal_plo[31:16]}, 16);
        p3 = sext({16'd0, cal_plo[47:32]}, 16);
        p4 = sext({16'd0, cal_plo[63:48]}, 16);
        p5 = sext({16'd0, cal_phi[15:0]}, 16);
        p6 = sext({16'd0, cal_phi[31:16]}, 16);
        p7 = sext({16'd0, cal_phi[47:32]}, 16);
        p8 = sext({16'd0, cal_phi[63:48]}, 16);
        p9 = sext({16'd0, cal_p9}, 16);
        r = '0;
        a = sra(fine_t, 1) - 32'd64000;
        q = sra(a, 2);
        sq = q * q;
        b = sra(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 0)
        begin
            r.zdiv = 1'b1;
            return r;
        end
        p = ((32'd1048576 - adc) - sra(b, 12)) * 32'd3125;
        if (p < 32'h80000000)
            p = (p << 1) / a;
        else
            p = (p / a) * 32'd2;
        ps = p >> 3;
        a = sra(p9 * ((ps * ps) >> 13), 12);
        b = sra((p >> 2) * p8, 13);
        p = p + sra(a + b + p7, 4);
        r.value = {1'b0, p};
        return r;
    endfunction

    // humidity in %RH*100, clamped
    function automatic comp_t calc_humid(input logic [31:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, c, d, e, f, x;
        comp_t       r;
        h1 = {24'd0, cal_hum[7:0]};
        h2 = sext({16'd0, cal_hum[23:8]}, 16);
        h3 = {24'd0, cal_hum[31:24]};
        h4 = sext({20'd0, cal_hum[43:32]}, 12);
        h5 = sext({20'd0, cal_hum[55:44]}, 12);
        h6 = sext({24'd0, cal_hum[63:56]}, 8);
        v = fine_t - 32'd76800;
        a = ((adc & 32'hFFFF) << 14) - (h4 << 20) - h5 * v;
        a = sra(a + 32'd16384, 15);
        b = sra(v * h6, 10);
        c = sra(v * h3, 11) + 32'd32768;
        d = sra(b * c, 10) + 32'd2097152;
        e = sra(d * h2 + 32'd8192, 14);
        x = a * e;
        f = sra(sra(sra(x, 15) * sra(x, 15), 7) * h1, 4);
        x = x - f;
        if ($signed(x) < 0)
            x = 0;
        if ($signed(x) > 419430400)
            x = 419430400;
        r.value = {1'b0, ((x >> 12) * 32'd25) >> 8};
        r.zdiv = 1'b0;
        return r;
    endfunction

    function automatic comp_t compensate(input sample_t s);
        comp_t r;
        r = '0;
        case (s.op)
            OP_TEMP:  r = calc_temp({12'd0, s.raw});
            OP_PRESS: r = calc_press({12'd0, s.raw});
            OP_HUMID: r = calc_humid({12'd0, s.raw});
            default:  r = '0;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= OP_TEMP;
            raw_value <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_readings.push_back(compensate({operation, raw_value}));
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                sample_t s;
                s = pending_samples.pop_front();
                in_valid  <= 1'b1;
                operation <= s.op;
                raw_value <= s.raw;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                comp_t e;
                if (expected_readings.size() == 0)
                begin
                    $error("unexpected reading %0h", reading);
                    fail_count++;
                end
                else
                begin
                    e = expected_readings.pop_front();
                    if (reading !== e.value)
                    begin
                        $error("reading: expected %0h got %0h", e.value, reading);
                        fail_count++;
                    end
                    if (zero_divisor !== e.zdiv)
                    begin
                        $error("zero_divisor: expected %0b got %0b", e.zdiv, zero_divisor);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one register write, after which cfg_valid is dropped before the task returns
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP:       cal_temp = val[47:0];
            REG_PRESS_LOW:  cal_plo = val;
            REG_PRESS_HIGH: cal_phi = val;
            REG_PRESS_NINE: cal_p9 = val[15:0];
            REG_HUMID:      cal_hum = val;
            REG_OFFSET:     cal_ofs = val[15:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // wait until every queued sample is sent and answered
    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // typical datasheet-like calibration set
    task automatic load_typical();
        write_reg(REG_TEMP, {16'd50, 16'd26435, 16'd27504});
        write_reg(REG_PRESS_LOW, {16'd2855, -16'sd10685, 16'd8501, 16'd36477});
        write_reg(REG_PRESS_HIGH, {16'd15500, -16'sd14600, -16'sd7, 16'd140});
        write_reg(REG_PRESS_NINE, 64'd6000);
        write_reg(REG_HUMID, {8'd30, 12'd50, 12'd339, 8'd0, 16'd361, 8'd75});
    endtask

    function automatic logic [19:0] rand_raw();
        case ($urandom_range(3))
            0:       return 20'($urandom_range(400000, 600000));
            1:       return 20'($urandom_range(250000, 350000));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        sample_t s;
        repeat (n)
        begin
            s.op  = 2'($urandom_range(99) < 3 ? OP_NONE : $urandom_range(2));
            s.raw = rand_raw();
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        sample_t s;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 11;
        recv_idle_pct = 52;
        cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0; cal_hum = '0;
        cal_ofs = '0; fine_t = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TEMP;
        cfg_data  = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero coefficients: zero divisor on pressure
        s.op = OP_TEMP;  s.raw = 20'hFFFFF; pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'd0;     pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'hFFFFF; pending_samples.push_back(s);
        s.op = OP_NONE;  s.raw = 20'h5A5A5; pending_samples.push_back(s);
        drain();

        // typical set, extremes of raw values and offsets
        load_typical();
        write_reg(REG_OFFSET, 64'h7FFF);
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        s.op = OP_TEMP;  s.raw = 20'd519888; pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'd415148; pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'd30000;  pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'hF0000;  pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'd0;      pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'hFFFF;   pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'hFFFFF;  pending_samples.push_back(s);
        s.op = OP_TEMP;  s.raw = 20'd0;      pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'd0;      pending_samples.push_back(s);
        drain();
        write_reg(REG_OFFSET, 64'hFFFF_FFFF_FFFF_8000);
        s.op = OP_TEMP;  s.raw = 20'hFFFFF;  pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'd300000; pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'd40000;  pending_samples.push_back(s);
        drain();
        write_reg(REG_TEMP, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_LOW, '1);
        write_reg(REG_PRESS_HIGH, '1);
        write_reg(REG_PRESS_NINE, 64'h8000);
        write_reg(REG_HUMID, '1);
        s.op = OP_TEMP;  s.raw = 20'hAAAAA;  pending_samples.push_back(s);
        s.op = OP_PRESS; s.raw = 20'h55555;  pending_samples.push_back(s);
        s.op = OP_HUMID; s.raw = 20'hFFFF;   pending_samples.push_back(s);
        drain();

        // random phases: typical coefficients with a random offset alternate with fully random coefficients
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 11;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph % 2 == 0)
            begin
                load_typical();
                write_reg(REG_OFFSET, 64'($urandom_range(65535)));
            end
            else
            begin
                write_reg(REG_TEMP, {$urandom, $urandom});
                write_reg(REG_PRESS_LOW, {$urandom, $urandom});
                write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
                write_reg(REG_PRESS_NINE, 64'($urandom));
                write_reg(REG_HUMID, {$urandom, $urandom});
                write_reg(REG_OFFSET, 64'($urandom));
                write_reg(3'($urandom_range(6, 7)), {$urandom, $urandom});
            end
            queue_random(205);
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
